>>> rtl/mlte_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the mission list transfer engine.
// No dependencies; imported by every module of the block.
package mlte_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam logic [23:0] TIMEOUT_RESET = 24'd5000000;
    localparam logic [7:0]  OWN_SYSID_RESET = 8'd1;

    localparam logic [2:0] MODE_REQ_LIST = 3'd0;
    localparam logic [2:0] MODE_REQ_ITEM = 3'd1;
    localparam logic [2:0] MODE_ACK      = 3'd2;
    localparam logic [2:0] MODE_COUNT    = 3'd3;
    localparam logic [2:0] MODE_ITEM     = 3'd4;
    localparam logic [2:0] MODE_CLEAR    = 3'd5;
    localparam logic [2:0] MODE_SET_CUR  = 3'd6;
    localparam logic [2:0] MODE_TICK     = 3'd7;

    localparam logic [2:0] KIND_COUNT   = 3'd0;
    localparam logic [2:0] KIND_ITEM    = 3'd1;
    localparam logic [2:0] KIND_REQUEST = 3'd2;
    localparam logic [2:0] KIND_ACK     = 3'd3;
    localparam logic [2:0] KIND_CURRENT = 3'd4;
    localparam logic [2:0] KIND_PERSIST = 3'd5;

    localparam logic [1:0] ACK_ACCEPTED = 2'd0;
    localparam logic [1:0] ACK_INV_SEQ  = 2'd1;
    localparam logic [1:0] ACK_NO_SPACE = 2'd2;

    localparam logic [0:0] REG_OWN_SYSID = 1'b0;
    localparam logic [0:0] REG_TIMEOUT   = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_SENDLIST = 5'b00010,
        PH_SENDWPS  = 5'b00100,
        PH_GETLIST  = 5'b01000,
        PH_GETWPS   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [63:0] zcfa;
        logic [63:0] xy;
        logic [63:0] p34;
        logic [63:0] p12;
    } wp_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  src_sysid;
        logic [7:0]  src_compid;
        logic [7:0]  tgt_sysid;
        logic [15:0] seq;
        logic [15:0] count;
        logic        item_current;
        wp_t         wp;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  dest_sysid;
        logic [7:0]  dest_compid;
        logic [15:0] out_seq;
        logic [15:0] out_count;
        logic [1:0]  ack_code;
        logic        out_current;
        wp_t         wp;
        logic        last;
    } res_t;

endpackage

>>> rtl/mission_list_transfer_engine_unit.sv
`timescale 1ns / 1ps
// Mission list transfer engine: waypoint-list handshake with a payload memory.
// The memory is read at acceptance into its registered read port, alongside the input stage;
// the item is processed from the input stage and its results go into the output queue.
// A new item is accepted only after the previous one has left the input stage;
// each item waits in the input stage until the previous results are all taken.
// Reset: asynchronous, active low; phase idle, store empty, no memory clearing pass.
module mission_list_transfer_engine_unit import mlte_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // src_sysid, src_compid, tgt_sysid, seq, count, item_current,
    // item_p12, item_p34, item_xy, item_zcfa, zero fill
    input  logic [319:0] s_tdata,
    input  logic [2:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    // dest_sysid, dest_compid, out_seq, out_count, ack_code, out_current,
    // out_p12, out_p34, out_xy, out_zcfa, zero fill
    output logic [311:0] m_tdata,
    output logic [2:0]   m_tuser,   // kind
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [16:0] CAP17 = 17'(CAPACITY);
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    in_t         in_reg;
    logic        in_valid_reg;
    logic        proc;
    in_t         in_w;

    logic [7:0]  own_sysid_reg;
    logic [23:0] timeout_reg;

    phase_t      phase_reg, phase_next;
    logic [16:0] exp_reg, exp_next;
    logic [15:0] tc_reg, tc_next;
    logic [7:0]  psys_reg, psys_next;
    logic [7:0]  pcomp_reg, pcomp_next;
    logic [23:0] idle_reg, idle_next;
    logic [LW-1:0] list_reg, list_next;
    logic [16:0] active_reg, active_next;
    logic [CAPACITY-1:0] flags_reg;

    logic        wr_en;
    logic        set_cur;
    wp_t         rd_data;
    logic [1:0]  nres;
    res_t        r0, r1, head;
    logic        oq_empty;

    logic        for_me, from_partner, in_range, ok;
    logic [16:0] seq17, exp_inc;
    logic [16:0] list17;

    // Unpack the slave item
    assign in_w.mode          = s_tuser;
    assign in_w.src_sysid     = s_tdata[7:0];
    assign in_w.src_compid    = s_tdata[15:8];
    assign in_w.tgt_sysid     = s_tdata[23:16];
    assign in_w.seq           = s_tdata[39:24];
    assign in_w.count         = s_tdata[55:40];
    assign in_w.item_current  = s_tdata[56];
    assign in_w.wp.p12        = s_tdata[120:57];
    assign in_w.wp.p34        = s_tdata[184:121];
    assign in_w.wp.xy         = s_tdata[248:185];
    assign in_w.wp.zcfa       = s_tdata[312:249];

    assign s_tready  = !in_valid_reg;
    assign cfg_ready = 1'b1;
    assign proc      = in_valid_reg && oq_empty;

    // Read on accept, write on update: the two never share an edge
    mlte_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (in_reg.seq[AW-1:0]),
        .wr_data (in_reg.wp),
        .rd_en   (s_tvalid && s_tready),
        .rd_addr (in_w.seq[AW-1:0]),
        .rd_data (rd_data)
    );

    mlte_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (nres),
        .push0      (r0),
        .push1      (r1),
        .empty      (oq_empty),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tuser = head.kind;
    assign m_tlast = head.last;
    assign m_tdata = {5'd0, head.wp.zcfa, head.wp.xy, head.wp.p34, head.wp.p12,
                      head.out_current, head.ack_code, head.out_count, head.out_seq,
                      head.dest_compid, head.dest_sysid};

    assign for_me       = (in_reg.tgt_sysid == own_sysid_reg);
    assign from_partner = (in_reg.src_sysid == psys_reg) && (in_reg.src_compid == pcomp_reg);
    assign seq17        = {1'b0, in_reg.seq};
    assign in_range     = (seq17 < CAP17);
    assign exp_inc      = exp_reg + 17'd1;
    assign list17       = 17'(list_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        exp_next    = exp_reg;
        tc_next     = tc_reg;
        psys_next   = psys_reg;
        pcomp_next  = pcomp_reg;
        idle_next   = idle_reg;
        list_next   = list_reg;
        active_next = active_reg;
        wr_en       = 1'b0;
        set_cur     = 1'b0;
        nres        = 2'd0;
        r0          = '0;
        r1          = '0;
        ok          = 1'b0;
        if (proc)
        begin
            unique case (in_reg.mode)
                MODE_REQ_LIST:
                begin
                    if (for_me && (phase_reg == PH_IDLE || phase_reg == PH_SENDLIST))
                    begin
                        if (list_reg != '0)
                        begin
                            phase_next = PH_SENDLIST;
                        end
                        idle_next      = '0;
                        exp_next       = '0;
                        psys_next      = in_reg.src_sysid;
                        pcomp_next     = in_reg.src_compid;
                        tc_next        = 16'(list_reg);
                        r0.kind        = KIND_COUNT;
                        r0.dest_sysid  = in_reg.src_sysid;
                        r0.dest_compid = in_reg.src_compid;
                        r0.out_count   = 16'(list_reg);
                        r0.last        = 1'b1;
                        nres           = 2'd1;
                    end
                end
                MODE_REQ_ITEM:
                begin
                    ok = (phase_reg == PH_SENDLIST && in_reg.seq == 16'd0) ||
                         (phase_reg == PH_SENDWPS &&
                          (seq17 == exp_reg || seq17 == exp_inc) && seq17 < list17);
                    if (from_partner && for_me && ok)
                    begin
                        idle_next      = '0;
                        phase_next     = PH_SENDWPS;
                        exp_next       = seq17;
                        r0.kind        = KIND_ITEM;
                        r0.dest_sysid  = in_reg.src_sysid;
                        r0.dest_compid = in_reg.src_compid;
                        r0.out_seq     = in_reg.seq;
                        if (in_range)
                        begin
                            r0.out_current = flags_reg[in_reg.seq[AW-1:0]];
                            r0.wp          = rd_data;
                        end
                        r0.last        = 1'b1;
                        nres           = 2'd1;
                    end
                end
                MODE_ACK:
                begin
                    if (from_partner && for_me &&
                        (phase_reg == PH_SENDLIST || phase_reg == PH_SENDWPS) &&
                        exp_reg == list17 - 17'd1)
                    begin
                        idle_next  = '0;
                        phase_next = PH_IDLE;
                        exp_next   = '0;
                    end
                end
                MODE_COUNT:
                begin
                    if (for_me && in_reg.count != 16'd0 &&
                        (phase_reg == PH_IDLE ||
                         (phase_reg == PH_GETLIST && exp_reg == 17'd0)))
                    begin
                        idle_next      = '0;
                        phase_next     = PH_GETLIST;
                        exp_next       = '0;
                        psys_next      = in_reg.src_sysid;
                        pcomp_next     = in_reg.src_compid;
                        tc_next        = in_reg.count;
                        r0.kind        = KIND_REQUEST;
                        r0.dest_sysid  = in_reg.src_sysid;
                        r0.dest_compid = in_reg.src_compid;
                        r0.last        = 1'b1;
                        nres           = 2'd1;
                    end
                end
                MODE_ITEM:
                begin
                    if (for_me)
                    begin
                        idle_next      = '0;
                        r0.dest_sysid  = psys_reg;
                        r0.dest_compid = pcomp_reg;
                        if (phase_reg != PH_GETLIST && phase_reg != PH_GETWPS)
                        begin
                            r0.kind     = KIND_ACK;
                            r0.ack_code = ACK_INV_SEQ;
                            r0.last     = 1'b1;
                            nres        = 2'd1;
                        end
                        else
                        begin
                            if (seq17 == exp_reg && in_reg.seq < tc_reg)
                            begin
                                phase_next = PH_GETWPS;
                                wr_en      = in_range;
                                exp_next   = seq17 + 17'd1;
                            end
                            r1.kind = KIND_PERSIST;
                            r1.last = 1'b1;
                            if (!in_range)
                            begin
                                list_next    = CAP_L;
                                phase_next   = PH_IDLE;
                                r0.kind      = KIND_ACK;
                                r0.ack_code  = ACK_NO_SPACE;
                                r1.out_count = 16'(CAP_L);
                                nres         = 2'd2;
                            end
                            else if (exp_next == {1'b0, tc_reg})
                            begin
                                list_next    = ({1'b0, tc_reg} > CAP17) ? CAP_L
                                                                        : LW'(tc_reg);
                                phase_next   = PH_IDLE;
                                r0.kind      = KIND_ACK;
                                r0.ack_code  = ACK_ACCEPTED;
                                r1.out_count = 16'(list_next);
                                nres         = 2'd2;
                            end
                            else
                            begin
                                r0.kind    = KIND_REQUEST;
                                r0.out_seq = exp_next[15:0];
                                r0.last    = 1'b1;
                                nres       = 2'd1;
                            end
                        end
                    end
                end
                MODE_CLEAR:
                begin
                    if (for_me && phase_reg == PH_IDLE)
                    begin
                        idle_next      = '0;
                        list_next      = '0;
                        r0.kind        = KIND_ACK;
                        r0.dest_sysid  = in_reg.src_sysid;
                        r0.dest_compid = in_reg.src_compid;
                        r0.ack_code    = ACK_ACCEPTED;
                        r1.kind        = KIND_PERSIST;
                        r1.last        = 1'b1;
                        nres           = 2'd2;
                    end
                end
                MODE_SET_CUR:
                begin
                    active_next = seq17;
                    set_cur     = 1'b1;
                    r0.kind     = KIND_CURRENT;
                    r0.out_seq  = in_reg.seq;
                    r0.last     = 1'b1;
                    nres        = 2'd1;
                end
                MODE_TICK:
                begin
                    if (idle_reg != 24'hFFFFFF)
                    begin
                        idle_next = idle_reg + 24'd1;
                    end
                    // Abandon a stalled exchange
                    if (idle_next > timeout_reg && phase_reg != PH_IDLE)
                    begin
                        phase_next  = PH_IDLE;
                        tc_next     = '0;
                        psys_next   = '0;
                        pcomp_next  = '0;
                        exp_next    = '1;
                        active_next = '1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            own_sysid_reg <= OWN_SYSID_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            phase_reg     <= PH_IDLE;
            exp_reg       <= '0;
            tc_reg        <= '0;
            psys_reg      <= '0;
            pcomp_reg     <= '0;
            idle_reg      <= '0;
            list_reg      <= '0;
            active_reg    <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_OWN_SYSID: own_sysid_reg <= cfg_data[7:0];
                    REG_TIMEOUT:   timeout_reg   <= cfg_data;
                    default:       timeout_reg   <= timeout_reg;
                endcase
            end
            phase_reg  <= phase_next;
            exp_reg    <= exp_next;
            tc_reg     <= tc_next;
            psys_reg   <= psys_next;
            pcomp_reg  <= pcomp_next;
            idle_reg   <= idle_next;
            list_reg   <= list_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= in_w;
        end
    end

    // Current flags: one write per item, or a rewrite of all stored entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (set_cur && (LW'(i) < list_reg))
            begin
                flags_reg[i] <= (in_reg.seq == 16'(i));
            end
            else if (wr_en && (in_reg.seq[AW-1:0] == AW'(i)))
            begin
                flags_reg[i] <= in_reg.item_current;
            end
        end
    end

`ifndef ASSERT_OFF
    a_proc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> !in_valid_reg) else $error("input stage not released");
    a_sendlist_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SENDLIST) |-> (list_reg != '0)) else $error("empty list sent");
    a_list_cap: assert property (@(posedge clk) disable iff (!rst_n)
        list_reg <= CAP_L) else $error("list size above capacity");
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (in_range && proc)) else $error("store write out of range");
`endif

endmodule

>>> rtl/mlte_store.sv
`timescale 1ns / 1ps
// Waypoint payload memory: one write port, one registered read port.
// Depends on mlte_pkg for the payload type.
module mlte_store import mlte_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT,
    parameter int AW = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  wp_t           wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output wp_t           rd_data
);

    wp_t mem [CAPACITY];
    wp_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mlte_outq.sv
`timescale 1ns / 1ps
// Two-slot result queue feeding the master stream side.
// Depends on mlte_pkg for the result type.
module mlte_outq import mlte_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  res_t       push0,
    input  res_t       push1,
    output logic       empty,
    output logic       head_valid,
    input  logic       head_ready,
    output res_t       head
);

    res_t       slot0_reg;
    res_t       slot1_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign pop        = head_valid && head_ready;
    assign empty      = (cnt_reg == 2'd0);
    assign head_valid = !empty;
    assign head       = slot0_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push_n != 2'd0)
        begin
            cnt_next = push_n;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Fill only when empty, so a push never meets a pop
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            slot0_reg <= push0;
            slot1_reg <= push1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

`ifndef ASSERT_OFF
    a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> empty) else $error("push into busy queue");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overrun");
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !slot0_reg.last) else $error("last on first of pair");
`endif

endmodule
